@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the quadratic root solver.
// No dependencies; the solver, checker and testbench refer to this package by scoped names.
package qrs_pkg;

    localparam int COEF_BITS = 16;
    localparam int ROOT_BITS = 40;
    localparam int CODE_BITS = 3;

    localparam logic [CODE_BITS-1:0] CASE_INFINITE = 3'd0;
    localparam logic [CODE_BITS-1:0] CASE_NONE     = 3'd1;
    localparam logic [CODE_BITS-1:0] CASE_LINEAR   = 3'd2;
    localparam logic [CODE_BITS-1:0] CASE_TWO_REAL = 3'd3;
    localparam logic [CODE_BITS-1:0] CASE_DOUBLE   = 3'd4;
    localparam logic [CODE_BITS-1:0] CASE_COMPLEX  = 3'd5;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] coef_quad;
        logic signed [COEF_BITS-1:0] coef_lin;
        logic signed [COEF_BITS-1:0] coef_const;
    } request_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]        case_code;
        logic signed [ROOT_BITS-1:0] root_one;
        logic signed [ROOT_BITS-1:0] root_two;
    } result_t;

endpackage

@@ rtl/qrs_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per register stage.
// Carries an opaque side vector alongside; no package dependencies.
module qrs_sqrt_pipe #(
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic                 v_out [ROOT_W];
    logic [RAD_W-1:0]     x_out [ROOT_W];
    logic [ROOT_W-1:0]    r_out [ROOT_W];
    logic [REM_W-1:0]     m_out [ROOT_W];
    logic [SIDE_W-1:0]    s_out [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_prev;
        logic [RAD_W-1:0]  x_prev;
        logic [ROOT_W-1:0] r_prev;
        logic [REM_W-1:0]  m_prev;
        logic [SIDE_W-1:0] s_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic              v_reg;
        logic [RAD_W-1:0]  x_reg;
        logic [ROOT_W-1:0] r_reg;
        logic [REM_W-1:0]  m_reg;
        logic [SIDE_W-1:0] s_reg;

        if (k == 0) begin : g_first
            assign v_prev = in_valid;
            assign x_prev = radicand;
            assign r_prev = '0;
            assign m_prev = '0;
            assign s_prev = side_in;
        end
        else begin : g_next
            assign v_prev = v_out[k-1];
            assign x_prev = x_out[k-1];
            assign r_prev = r_out[k-1];
            assign m_prev = m_out[k-1];
            assign s_prev = s_out[k-1];
        end

        // bring down the next two radicand bits, try (root*4 + 1)
        assign rem_sh = {m_prev[ROOT_W-1:0], x_prev[RAD_W-1 -: 2]};
        assign trial  = {r_prev, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else
                v_reg <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            x_reg <= x_prev << 2;
            r_reg <= {r_prev[ROOT_W-2:0], ge};
            m_reg <= ge ? (rem_sh - trial) : rem_sh;
            s_reg <= s_prev;
        end

        assign v_out[k] = v_reg;
        assign x_out[k] = x_reg;
        assign r_out[k] = r_reg;
        assign m_out[k] = m_reg;
        assign s_out[k] = s_reg;
    end

    assign out_valid = v_out[ROOT_W-1];
    assign root      = r_out[ROOT_W-1];
    assign side_out  = s_out[ROOT_W-1];

endmodule

@@ rtl/qrs_div_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Carries an opaque side vector alongside; no package dependencies.
module qrs_div_pipe #(
    parameter int NUM_W  = 34,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quot,
    output logic [SIDE_W-1:0] side_out
);

    logic              v_out [NUM_W];
    logic [NUM_W-1:0]  n_out [NUM_W];
    logic [DEN_W-1:0]  d_out [NUM_W];
    logic [DEN_W-1:0]  m_out [NUM_W];
    logic [SIDE_W-1:0] s_out [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              v_prev;
        logic [NUM_W-1:0]  n_prev;
        logic [DEN_W-1:0]  d_prev;
        logic [DEN_W-1:0]  m_prev;
        logic [SIDE_W-1:0] s_prev;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic              v_reg;
        logic [NUM_W-1:0]  n_reg;
        logic [DEN_W-1:0]  d_reg;
        logic [DEN_W-1:0]  m_reg;
        logic [SIDE_W-1:0] s_reg;

        if (k == 0) begin : g_first
            assign v_prev = in_valid;
            assign n_prev = num;
            assign d_prev = den;
            assign m_prev = '0;
            assign s_prev = side_in;
        end
        else begin : g_next
            assign v_prev = v_out[k-1];
            assign n_prev = n_out[k-1];
            assign d_prev = d_out[k-1];
            assign m_prev = m_out[k-1];
            assign s_prev = s_out[k-1];
        end

        // shift the next numerator bit into the remainder; quotient bits
        // fill the numerator from the bottom
        assign trial = {m_prev, n_prev[NUM_W-1]};
        assign diff  = trial - {1'b0, d_prev};
        assign ge    = (trial >= {1'b0, d_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else
                v_reg <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            n_reg <= {n_prev[NUM_W-2:0], ge};
            d_reg <= d_prev;
            m_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            s_reg <= s_prev;
        end

        assign v_out[k] = v_reg;
        assign n_out[k] = n_reg;
        assign d_out[k] = d_reg;
        assign m_out[k] = m_reg;
        assign s_out[k] = s_reg;
    end

    assign out_valid = v_out[NUM_W-1];
    assign quot      = n_out[NUM_W-1];
    assign side_out  = s_out[NUM_W-1];

endmodule

@@ rtl/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// Quadratic root solver: input register, products of magnitudes, discriminant
// magnitude and case, scaled square root, numerators and divisors, dividers and
// output register; the square root and the dividers resolve one bit per stage.
// Throughput one request per cycle; busy stays low, the receiver cannot stall.
// Reset clears the valid bits only; no request in flight survives reset.
// Depends on qrs_pkg, qrs_sqrt_pipe and qrs_div_pipe.
module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  qrs_pkg::request_t  request,
    output logic               busy,
    output logic               done,
    output qrs_pkg::result_t   result
);

    localparam int CB      = qrs_pkg::COEF_BITS;
    localparam int CW      = qrs_pkg::CODE_BITS;
    localparam int RB      = qrs_pkg::ROOT_BITS;
    localparam int PW      = 2 * CB;
    localparam int DMW     = 2 * CB + 1;
    localparam int SQ_W    = (DMW + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W   = 2 * SQ_W;
    localparam int NUM_W   = ((CB + FRAC_BITS > SQ_W) ? CB + FRAC_BITS : SQ_W) + 1;
    localparam int XW      = NUM_W + 1;
    localparam int DVW     = CB + 1;
    localparam int QXW     = (XW > RB) ? XW : RB;
    localparam int SIDE_W  = CW + 3 * CB;
    localparam int LATENCY = 5 + SQ_W + NUM_W;

    // ---------------- input register
    logic                 v0_reg;
    logic signed [CB-1:0] a0_reg, b0_reg, c0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        a0_reg <= request.coef_quad;
        b0_reg <= request.coef_lin;
        c0_reg <= request.coef_const;
    end

    // ---------------- products of magnitudes
    logic [CB-1:0]        a_mag, b_mag, c_mag;
    logic                 v1_reg;
    logic [PW-1:0]        bb1_reg, ac1_reg;
    logic signed [CB-1:0] a1_reg, b1_reg, c1_reg;

    assign a_mag = a0_reg[CB-1] ? CB'(-a0_reg) : CB'(a0_reg);
    assign b_mag = b0_reg[CB-1] ? CB'(-b0_reg) : CB'(b0_reg);
    assign c_mag = c0_reg[CB-1] ? CB'(-c0_reg) : CB'(c0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        bb1_reg <= PW'(b_mag) * PW'(b_mag);
        ac1_reg <= PW'(a_mag) * PW'(c_mag);
        a1_reg  <= a0_reg;
        b1_reg  <= b0_reg;
        c1_reg  <= c0_reg;
    end

    // ---------------- discriminant magnitude and case
    logic [DMW-1:0] bb_x, ac4_x, dm_next;
    logic           dneg;
    logic [CW-1:0]  code_next;
    logic           v2_reg;
    logic [DMW-1:0] dm2_reg;
    logic [SIDE_W-1:0] side2_reg;

    assign bb_x  = DMW'(bb1_reg);
    assign ac4_x = DMW'(ac1_reg) << 2;

    always_comb
    begin
        dneg = 1'b0;
        if (a1_reg[CB-1] != c1_reg[CB-1])
            dm_next = bb_x + ac4_x;
        else if (bb_x >= ac4_x)
            dm_next = bb_x - ac4_x;
        else
        begin
            dm_next = ac4_x - bb_x;
            dneg    = 1'b1;
        end
    end

    always_comb
    begin
        priority if (a1_reg == '0 && b1_reg == '0)
            code_next = (c1_reg == '0) ? qrs_pkg::CASE_INFINITE : qrs_pkg::CASE_NONE;
        else if (a1_reg == '0)
            code_next = qrs_pkg::CASE_LINEAR;
        else if (dm_next == '0)
            code_next = qrs_pkg::CASE_DOUBLE;
        else if (dneg)
            code_next = qrs_pkg::CASE_COMPLEX;
        else
            code_next = qrs_pkg::CASE_TWO_REAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        dm2_reg   <= dm_next;
        side2_reg <= {code_next, a1_reg, b1_reg, c1_reg};
    end

    // ---------------- scaled square root
    logic              sq_valid;
    logic [SQ_W-1:0]   sq_root;
    logic [SIDE_W-1:0] sq_side;

    qrs_sqrt_pipe #(
        .ROOT_W (SQ_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .radicand  (RAD_W'(dm2_reg) << (2 * FRAC_BITS)),
        .side_in   (side2_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ---------------- numerators and divisors
    logic [CW-1:0]         code3;
    logic signed [CB-1:0]  a3, b3, c3;
    logic signed [XW-1:0]  b_x, c_x, s_x, nb_x, nc_x, n1_x, n2_x;
    logic signed [DVW-1:0] den_x;
    logic                  v3_reg;
    logic [NUM_W-1:0]      n1_reg, n2_reg;
    logic [DVW-1:0]        d3_reg;
    logic                  neg1_reg, neg2_reg;
    logic [CW-1:0]         code3_reg;

    assign code3 = sq_side[SIDE_W-1 -: CW];
    assign a3    = sq_side[3*CB-1 -: CB];
    assign b3    = sq_side[2*CB-1 -: CB];
    assign c3    = sq_side[CB-1:0];
    assign b_x   = XW'(b3);
    assign c_x   = XW'(c3);
    assign s_x   = XW'(sq_root);
    assign nb_x  = -(b_x <<< FRAC_BITS);
    assign nc_x  = -(c_x <<< FRAC_BITS);

    always_comb
    begin
        unique case (code3)
            qrs_pkg::CASE_LINEAR:
            begin
                n1_x  = nc_x;
                n2_x  = '0;
                den_x = DVW'(b3);
            end
            qrs_pkg::CASE_TWO_REAL:
            begin
                n1_x  = nb_x + s_x;
                n2_x  = nb_x - s_x;
                den_x = {a3, 1'b0};
            end
            qrs_pkg::CASE_DOUBLE:
            begin
                n1_x  = nb_x;
                n2_x  = nb_x;
                den_x = {a3, 1'b0};
            end
            qrs_pkg::CASE_COMPLEX:
            begin
                n1_x  = nb_x;
                n2_x  = s_x;
                den_x = {a3, 1'b0};
            end
            default:
            begin
                // no root: divide zero by one
                n1_x  = '0;
                n2_x  = '0;
                den_x = DVW'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        n1_reg    <= n1_x[XW-1] ? NUM_W'(-n1_x) : NUM_W'(n1_x);
        n2_reg    <= n2_x[XW-1] ? NUM_W'(-n2_x) : NUM_W'(n2_x);
        d3_reg    <= den_x[DVW-1] ? DVW'(-den_x) : DVW'(den_x);
        neg1_reg  <= n1_x[XW-1] ^ den_x[DVW-1];
        neg2_reg  <= n2_x[XW-1] ^ den_x[DVW-1];
        code3_reg <= code3;
    end

    // ---------------- dividers
    logic             q1_valid, q2_valid;
    logic [NUM_W-1:0] q1, q2;
    logic [CW:0]      q1_side;
    logic             q2_neg;

    qrs_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DVW),
        .SIDE_W (CW + 1)
    ) u_div_one (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (n1_reg),
        .den       (d3_reg),
        .side_in   ({code3_reg, neg1_reg}),
        .out_valid (q1_valid),
        .quot      (q1),
        .side_out  (q1_side)
    );

    qrs_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DVW),
        .SIDE_W (1)
    ) u_div_two (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (n2_reg),
        .den       (d3_reg),
        .side_in   (neg2_reg),
        .out_valid (q2_valid),
        .quot      (q2),
        .side_out  (q2_neg)
    );

    // ---------------- sign, wrap to field width, output register
    logic signed [XW-1:0]  r1_x, r2_x;
    logic signed [QXW-1:0] r1_w, r2_w;
    logic                  done_reg;
    qrs_pkg::result_t      result_reg;

    assign r1_x = q1_side[0] ? -XW'(q1) : XW'(q1);
    assign r2_x = q2_neg     ? -XW'(q2) : XW'(q2);
    assign r1_w = QXW'(r1_x);
    assign r2_w = QXW'(r2_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= q1_valid & q2_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg.case_code <= q1_side[CW:1];
        result_reg.root_one  <= r1_w[RB-1:0];
        result_reg.root_two  <= r2_w[RB-1:0];
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/qrs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg and quadratic_root_solver.
module qrs_checker #(
    parameter int LATENCY = 72
) (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input qrs_pkg::result_t result
);

    // every accepted request yields a result after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("request produced no result at the fixed latency");

    // no result without a request at the matching edge
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.case_code == qrs_pkg::CASE_INFINITE ||
                 result.case_code == qrs_pkg::CASE_NONE)
        |-> result.root_one == '0 && result.root_two == '0)
        else $error("degenerate case with nonzero roots");

    a_double_root: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.case_code == qrs_pkg::CASE_DOUBLE
        |-> result.root_one == result.root_two)
        else $error("double root with differing values");

    a_linear_root: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.case_code == qrs_pkg::CASE_LINEAR |-> result.root_two == '0)
        else $error("linear case with nonzero second root");

endmodule

bind quadratic_root_solver qrs_checker #(
    .LATENCY (LATENCY)
) u_qrs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

@@ test/tb_quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_root_solver: a directed table, then random
// coefficient sets, checked against typed values or a bit-accurate root predictor.
// Depends on qrs_pkg and the solver RTL.
module tb_quadratic_root_solver;

    localparam int FRAC = 16;
    localparam int LATENCY = 4 + 2 * (FRAC + 17) + 20;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        qrs_pkg::request_t req;
        bit                typed;
        qrs_pkg::result_t  exp;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    qrs_pkg::request_t request;
    logic              busy;
    logic              done;
    qrs_pkg::result_t  result;

    qrs_pkg::result_t pending_roots[$];
    int      errors;
    longint  cycles;

    quadratic_root_solver #(.FRAC_BITS(FRAC)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic qrs_pkg::result_t solve_quadratic(qrs_pkg::request_t q);
        longint a, b, c, ma, mb, mc, nb, den, s, r1, r2;
        logic [127:0] b2, ac4, dm, scaled, t;
        logic [63:0] root;
        bit d_neg;
        logic [qrs_pkg::CODE_BITS-1:0] code;
        qrs_pkg::result_t r;
        a = q.coef_quad;
        b = q.coef_lin;
        c = q.coef_const;
        r1 = 0;
        r2 = 0;
        d_neg = 0;
        if (a == 0)
        begin
            if (b == 0)
                code = (c == 0) ? qrs_pkg::CASE_INFINITE : qrs_pkg::CASE_NONE;
            else
            begin
                code = qrs_pkg::CASE_LINEAR;
                r1 = (-c * (longint'(1) << FRAC)) / b;
            end
        end
        else
        begin
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            mc = (c < 0) ? -c : c;
            b2 = 128'(mb * mb);
            ac4 = 128'(ma * mc) << 2;
            if (((a < 0) != (c < 0)) || c == 0)
                dm = b2 + ac4;
            else if (b2 >= ac4)
                dm = b2 - ac4;
            else
            begin
                dm = ac4 - b2;
                d_neg = 1;
            end
            // floor of the square root, already scaled by 2^FRAC
            scaled = dm << (2 * FRAC);
            root = '0;
            for (int i = 63; i >= 0; i--)
            begin
                t = 128'(root | (64'd1 << i));
                if (t * t <= scaled)
                    root = t[63:0];
            end
            s = longint'(root);
            den = 2 * a;
            nb = -b * (longint'(1) << FRAC);
            if (dm == 0)
            begin
                code = qrs_pkg::CASE_DOUBLE;
                r1 = nb / den;
                r2 = r1;
            end
            else if (!d_neg)
            begin
                code = qrs_pkg::CASE_TWO_REAL;
                r1 = (nb + s) / den;
                r2 = (nb - s) / den;
            end
            else
            begin
                code = qrs_pkg::CASE_COMPLEX;
                r1 = nb / den;
                r2 = s / den;
            end
        end
        r.case_code = code;
        r.root_one = r1[qrs_pkg::ROOT_BITS-1:0];
        r.root_two = r2[qrs_pkg::ROOT_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // check results as they leave the block
    always @(posedge clk)
    begin
        qrs_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_roots.size() == 0)
                report_mismatch("unexpected result, case", result.case_code, -1);
            else
            begin
                want = pending_roots.pop_front();
                if (result.case_code !== want.case_code)
                    report_mismatch("case_code", result.case_code, want.case_code);
                if (result.root_one !== want.root_one)
                    report_mismatch("root_one", result.root_one, want.root_one);
                if (result.root_two !== want.root_two)
                    report_mismatch("root_two", result.root_two, want.root_two);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quadratic_root_solver regression: fail");
            $finish;
        end
    end

    function automatic qrs_pkg::request_t mk(int a, int b, int c);
        qrs_pkg::request_t q;
        q.coef_quad = a[qrs_pkg::COEF_BITS-1:0];
        q.coef_lin = b[qrs_pkg::COEF_BITS-1:0];
        q.coef_const = c[qrs_pkg::COEF_BITS-1:0];
        return q;
    endfunction

    function automatic qrs_pkg::result_t res(logic [qrs_pkg::CODE_BITS-1:0] code,
                                             longint r1, longint r2);
        qrs_pkg::result_t r;
        r.case_code = code;
        r.root_one = r1[qrs_pkg::ROOT_BITS-1:0];
        r.root_two = r2[qrs_pkg::ROOT_BITS-1:0];
        return r;
    endfunction

    function automatic qrs_pkg::request_t random_coefs();
        int k, r, m, a, b, c;
        k = $urandom_range(9);
        if (k < 4)
            return mk($urandom, $urandom, $urandom);
        if (k < 6)
        begin
            m = 1 << $urandom_range(15);
            a = $urandom_range(2 * m) - m;
            b = $urandom_range(2 * m) - m;
            c = $urandom_range(2 * m) - m;
            if (k == 5)
                a = 0;
            return mk(a, b, c);
        end
        if (k < 8)
        begin
            // perfect square: double root unless the quadratic coefficient is zero
            a = $urandom_range(60) - 30;
            r = $urandom_range(40) - 20;
            return mk(a, -2 * a * r, a * r * r);
        end
        return mk($urandom_range(16) - 8, $urandom_range(16) - 8, $urandom_range(16) - 8);
    endfunction

    task automatic send_coefs(qrs_pkg::request_t q, int idle_pct, bit typed,
                              qrs_pkg::result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= q;
        do
            @(posedge clk);
        while (busy);
        pending_roots.push_back(typed ? want : solve_quadratic(q));
    endtask

    initial
    begin
        stim_row_t rows[$];
        int idle_pct [3];
        idle_pct[0] = 35;
        idle_pct[1] = 86;
        idle_pct[2] = 0;
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;

        rows.push_back('{mk(0, 0, 0), 1, res(qrs_pkg::CASE_INFINITE, 0, 0)});
        rows.push_back('{mk(0, 0, 5), 1, res(qrs_pkg::CASE_NONE, 0, 0)});
        rows.push_back('{mk(0, 0, -32768), 1, res(qrs_pkg::CASE_NONE, 0, 0)});
        rows.push_back('{mk(0, 2, -4), 1, res(qrs_pkg::CASE_LINEAR, 131072, 0)});
        rows.push_back('{mk(0, -1, -32768), 1,
                         res(qrs_pkg::CASE_LINEAR, -64'sd2147483648, 0)});
        rows.push_back('{mk(1, -2, 1), 1, res(qrs_pkg::CASE_DOUBLE, 65536, 65536)});
        rows.push_back('{mk(1, 0, -4), 1, res(qrs_pkg::CASE_TWO_REAL, 131072, -131072)});
        rows.push_back('{mk(1, 0, 4), 1, res(qrs_pkg::CASE_COMPLEX, 0, 131072)});
        rows.push_back('{mk(-1, 0, -4), 1, res(qrs_pkg::CASE_COMPLEX, 0, -131072)});
        rows.push_back('{mk(0, -32768, 32767), 0, '0});
        rows.push_back('{mk(0, 1, -32768), 0, '0});
        rows.push_back('{mk(0, 32767, -32768), 0, '0});
        rows.push_back('{mk(-32768, -32768, -32768), 0, '0});
        rows.push_back('{mk(32767, 32767, 32767), 0, '0});
        rows.push_back('{mk(-32768, 32767, 32767), 0, '0});
        rows.push_back('{mk(32767, -32768, -32768), 0, '0});
        rows.push_back('{mk(1, -32768, 0), 0, '0});
        rows.push_back('{mk(-32768, 0, 32767), 0, '0});
        rows.push_back('{mk(-32768, 0, -32768), 0, '0});
        rows.push_back('{mk(32767, 1, 0), 0, '0});
        rows.push_back('{mk(-1, -1, -1), 0, '0});
        rows.push_back('{mk(3, 5, -7), 0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_coefs(rows[i].req, idle_pct[0], rows[i].typed, rows[i].exp);
        for (int ph = 0; ph < 3; ph++)
            for (int n = 0; n < 460; n++)
                send_coefs(random_coefs(), idle_pct[ph], 0, '0);
        start <= 1'b0;

        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);

        if (errors == 0)
            $display("quadratic_root_solver regression: pass");
        else
            $display("quadratic_root_solver regression: fail");
        $finish;
    end
endmodule
